FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define DCZ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("dcz check failed");
`define DCZ_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("dcz check failed");
`define DCZ_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("dcz check failed");
`else
`define DCZ_ASSERT(lbl, clk, rst_n, prop)
`define DCZ_IMPLY(lbl, clk, rst_n, ante, cons)
`define DCZ_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/dcz_pkg.sv
// ----------------------------------------------------------------------------
// dcz_pkg
// shared types and constants of the cycle search block
// ----------------------------------------------------------------------------
package dcz_pkg;
    localparam int MAX_VERTS = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int VERT_W    = 10;
    localparam int EDGE_AW   = 12;
    localparam int LINK_W    = 13;
    localparam int LEN_W     = 11;
    localparam int WGT_W     = 32;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_EDGES);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOCYC = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ADD_WR, S_CLR, S_POP, S_POP_RD, S_HEAD,
        S_EDGE, S_SEEN, S_LEN, S_LEN_RD, S_RD, S_DONE
    } t_state;

    typedef struct packed {
        t_status                 status;
        logic [LEN_W-1:0]        path_len;
        logic [VERT_W-1:0]       out_to;
        logic signed [WGT_W-1:0] out_weight;
        logic [VERT_W-1:0]       out_from;
        logic                    last;
    } t_result;
endpackage

FILE: rtl/dfs_cycle_through_vertex_zero.sv
// ----------------------------------------------------------------------------
// dfs_cycle_through_vertex_zero
// depth-first search for a directed cycle through vertex 0
// ----------------------------------------------------------------------------
// Takes one request item at a time. An add-edge item does one list read
// and one write-back; a read item does one predecessor read. A search item
// first clears every entry of the visited memory, then reads each popped
// vertex from the stack and its list head, scans each edge with a target
// read and a visited check, and for a found cycle walks its predecessors
// back to vertex 0 to count its length; the registered read ports of the
// memories and the read-modify-write order of the walk set these steps.
// After reset every entry of the list head/tail memory is swept to null,
// during which no item is accepted. A finished result waits in an output
// register, so the next item may be taken while it is still pending.
module dfs_cycle_through_vertex_zero (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // edge_to, edge_weight, edge_from, zero pad
    input  logic [1:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // path_len, out_to, out_weight, out_from, zero pad
    output logic [1:0]  o_m_tuser,   // status
    output logic        o_m_tlast    // last
);
    import dcz_pkg::*;

    localparam int VADJ_W = VERT_W + WGT_W;          // target and weight
    localparam int LIST_W = 2 * LINK_W;              // head and tail

    // control state
    t_state              r_state, n_state;
    logic [VERT_W-1:0]   r_sweep, n_sweep;
    logic [LINK_W-1:0]   r_edges, n_edges;
    logic [LEN_W-1:0]    r_top, n_top;
    logic [LEN_W-1:0]    r_n, n_n;
    logic [VERT_W-1:0]   r_rd_v, n_rd_v;
    logic                r_rd_done, n_rd_done;
    // working payload
    logic [VERT_W-1:0]   r_from, n_from;
    logic [VERT_W-1:0]   r_v, n_v;
    logic [VERT_W-1:0]   r_t, n_t;
    logic [WGT_W-1:0]    r_w, n_w;
    logic [LINK_W-1:0]   r_link, n_link;
    t_result             r_res, n_res;

    // memory ports
    logic                adj_we;
    logic [EDGE_AW-1:0]  adj_waddr, adj_raddr;
    logic [VADJ_W-1:0]   adj_wdata, adj_rdata;
    logic                lnk_we;
    logic [EDGE_AW-1:0]  lnk_waddr, lnk_raddr;
    logic [LINK_W-1:0]   lnk_wdata, lnk_rdata;
    logic                lst_we;
    logic [VERT_W-1:0]   lst_waddr, lst_raddr;
    logic [LIST_W-1:0]   lst_wdata, lst_rdata;
    logic                seen_we;
    logic [VERT_W-1:0]   seen_waddr, seen_raddr;
    logic                seen_wdata, seen_rdata;
    logic                prd_we;
    logic [VERT_W-1:0]   prd_waddr, prd_raddr;
    logic [VADJ_W-1:0]   prd_wdata, prd_rdata;
    logic                stk_we;
    logic [VERT_W-1:0]   stk_waddr, stk_raddr;
    logic [VERT_W-1:0]   stk_wdata, stk_rdata;

    logic                out_load, out_can_load;
    logic                in_acc;

    // unpacked input fields
    logic [VERT_W-1:0]   in_to, in_from;
    logic [WGT_W-1:0]    in_w;
    t_req                in_req;

    assign in_to   = i_s_tdata[9:0];
    assign in_w    = i_s_tdata[41:10];
    assign in_from = i_s_tdata[51:42];
    assign in_req  = t_req'(i_s_tuser);

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;

    dcz_ram #(.WIDTH(VADJ_W), .DEPTH(MAX_EDGES)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata));
    dcz_ram #(.WIDTH(LINK_W), .DEPTH(MAX_EDGES)) u_link (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_waddr), .i_wdata(lnk_wdata),
        .i_raddr(lnk_raddr), .o_rdata(lnk_rdata));
    dcz_ram #(.WIDTH(LIST_W), .DEPTH(MAX_VERTS)) u_list (
        .i_clk(i_clk), .i_we(lst_we), .i_waddr(lst_waddr), .i_wdata(lst_wdata),
        .i_raddr(lst_raddr), .o_rdata(lst_rdata));
    dcz_ram #(.WIDTH(1), .DEPTH(MAX_VERTS)) u_seen (
        .i_clk(i_clk), .i_we(seen_we), .i_waddr(seen_waddr), .i_wdata(seen_wdata),
        .i_raddr(seen_raddr), .o_rdata(seen_rdata));
    dcz_ram #(.WIDTH(VADJ_W), .DEPTH(MAX_VERTS)) u_pred (
        .i_clk(i_clk), .i_we(prd_we), .i_waddr(prd_waddr), .i_wdata(prd_wdata),
        .i_raddr(prd_raddr), .o_rdata(prd_rdata));
    dcz_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata));

    dcz_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(out_load), .i_res(r_res),
        .o_can_load(out_can_load), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_sweep   <= '0;
            r_edges   <= '0;
            r_top     <= '0;
            r_n       <= '0;
            r_rd_v    <= '0;
            r_rd_done <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_sweep   <= n_sweep;
            r_edges   <= n_edges;
            r_top     <= n_top;
            r_n       <= n_n;
            r_rd_v    <= n_rd_v;
            r_rd_done <= n_rd_done;
        end
        r_from <= n_from;
        r_v    <= n_v;
        r_t    <= n_t;
        r_w    <= n_w;
        r_link <= n_link;
        r_res  <= n_res;
    end

    always_comb begin
        logic [LINK_W-1:0] head, tail;
        logic [VERT_W-1:0] at, pc;
        head = lst_rdata[LIST_W-1:LINK_W];
        tail = lst_rdata[LINK_W-1:0];
        at   = adj_rdata[VADJ_W-1:WGT_W];
        pc   = prd_rdata[VADJ_W-1:WGT_W];

        n_state = r_state;  n_sweep = r_sweep;  n_edges = r_edges;
        n_top = r_top;      n_n = r_n;          n_rd_v = r_rd_v;
        n_rd_done = r_rd_done;
        n_from = r_from;    n_v = r_v;          n_t = r_t;
        n_w = r_w;          n_link = r_link;    n_res = r_res;

        adj_we = 1'b0;  adj_waddr = '0; adj_wdata = '0; adj_raddr = '0;
        lnk_we = 1'b0;  lnk_waddr = '0; lnk_wdata = '0; lnk_raddr = '0;
        lst_we = 1'b0;  lst_waddr = '0; lst_wdata = '0; lst_raddr = '0;
        seen_we = 1'b0; seen_waddr = '0; seen_wdata = 1'b0; seen_raddr = '0;
        prd_we = 1'b0;  prd_waddr = '0; prd_wdata = '0; prd_raddr = '0;
        stk_we = 1'b0;  stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
        out_load = 1'b0;

        case (r_state)
            // sweep list heads and tails to null after reset
            S_INIT: begin
                lst_we    = 1'b1;
                lst_waddr = r_sweep;
                lst_wdata = {NIL_LINK, NIL_LINK};
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == VERT_W'(MAX_VERTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res  = '0;
                    n_from = in_from;
                    case (in_req)
                        REQ_ADD: begin
                            if (r_edges == NIL_LINK) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                // new entry written now, list linked next cycle
                                lst_raddr = in_from;
                                adj_we    = 1'b1;
                                adj_waddr = r_edges[EDGE_AW-1:0];
                                adj_wdata = {in_to, in_w};
                                lnk_we    = 1'b1;
                                lnk_waddr = r_edges[EDGE_AW-1:0];
                                lnk_wdata = NIL_LINK;
                                n_state   = S_ADD_WR;
                            end
                        end
                        REQ_SEARCH: begin
                            n_sweep = '0;
                            n_state = S_CLR;
                        end
                        REQ_READ: begin
                            if (r_rd_done) begin
                                n_res.status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                prd_raddr = r_rd_v;
                                n_state   = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_WR: begin
                lst_we    = 1'b1;
                lst_waddr = r_from;
                if (head == NIL_LINK) begin
                    lst_wdata = {r_edges, r_edges};
                end else begin
                    lst_wdata = {head, r_edges};
                    lnk_we    = 1'b1;
                    lnk_waddr = tail[EDGE_AW-1:0];
                    lnk_wdata = r_edges;
                end
                n_edges      = r_edges + 1'b1;
                n_res.status = ST_OK;
                n_state      = S_DONE;
            end
            // clear visited marks, then seed the stack with vertex 0
            S_CLR: begin
                seen_we    = 1'b1;
                seen_waddr = r_sweep;
                seen_wdata = 1'b0;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == VERT_W'(MAX_VERTS - 1)) begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = '0;
                    n_top     = LEN_W'(1);
                    n_state   = S_POP;
                end
            end
            S_POP: begin
                if (r_top == '0) begin
                    n_rd_done    = 1'b1;
                    n_res.status = ST_NOCYC;
                    n_state      = S_DONE;
                end else begin
                    stk_raddr = VERT_W'(r_top - 1'b1);
                    n_top     = r_top - 1'b1;
                    n_state   = S_POP_RD;
                end
            end
            S_POP_RD: begin
                n_v       = stk_rdata;
                lst_raddr = stk_rdata;
                n_state   = S_HEAD;
            end
            S_HEAD: begin
                if (head == NIL_LINK) begin
                    n_state = S_POP;
                end else begin
                    adj_raddr = head[EDGE_AW-1:0];
                    lnk_raddr = head[EDGE_AW-1:0];
                    n_state   = S_EDGE;
                end
            end
            S_EDGE: begin
                if (at == '0) begin
                    // edge back to vertex 0 closes the cycle
                    prd_we    = 1'b1;
                    prd_waddr = '0;
                    prd_wdata = {r_v, adj_rdata[WGT_W-1:0]};
                    n_state   = S_LEN;
                end else begin
                    seen_raddr = at;
                    n_t        = at;
                    n_w        = adj_rdata[WGT_W-1:0];
                    n_link     = lnk_rdata;
                    n_state    = S_SEEN;
                end
            end
            S_SEEN: begin
                if (!seen_rdata) begin
                    seen_we    = 1'b1;
                    seen_waddr = r_t;
                    seen_wdata = 1'b1;
                    prd_we     = 1'b1;
                    prd_waddr  = r_t;
                    prd_wdata  = {r_v, r_w};
                    if (r_top < LEN_W'(MAX_VERTS)) begin
                        stk_we    = 1'b1;
                        stk_waddr = r_top[VERT_W-1:0];
                        stk_wdata = r_t;
                        n_top     = r_top + 1'b1;
                    end
                end
                if (r_link == NIL_LINK) begin
                    n_state = S_POP;
                end else begin
                    adj_raddr = r_link[EDGE_AW-1:0];
                    lnk_raddr = r_link[EDGE_AW-1:0];
                    n_state   = S_EDGE;
                end
            end
            S_LEN: begin
                prd_raddr = '0;
                n_n       = LEN_W'(1);
                n_state   = S_LEN_RD;
            end
            // walk predecessors back to vertex 0, one step per cycle
            S_LEN_RD: begin
                if (pc == '0 || r_n == LEN_W'(MAX_VERTS)) begin
                    n_rd_v         = '0;
                    n_rd_done      = 1'b0;
                    n_res.status   = ST_OK;
                    n_res.path_len = r_n;
                    n_state        = S_DONE;
                end else begin
                    n_n       = r_n + 1'b1;
                    prd_raddr = pc;
                end
            end
            S_RD: begin
                n_res.status     = ST_OK;
                n_res.out_to     = r_rd_v;
                n_res.out_weight = prd_rdata[WGT_W-1:0];
                n_res.out_from   = pc;
                if (pc == '0) begin
                    n_res.last = 1'b1;
                    n_rd_done  = 1'b1;
                end else begin
                    n_rd_v = pc;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_can_load) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `include "assert_macros.svh"
    `DCZ_ASSERT(a_edges_bound, i_clk, i_rst_n, r_edges <= NIL_LINK)
    `DCZ_ASSERT(a_stack_bound, i_clk, i_rst_n, r_top <= LEN_W'(MAX_VERTS))
    `DCZ_NEXT(a_one_at_a_time, i_clk, i_rst_n, in_acc && in_req != REQ_NONE, !o_s_tready)
    `DCZ_IMPLY(a_load_from_done, i_clk, i_rst_n, out_load, r_state == S_DONE)
endmodule

FILE: rtl/dcz_ram.sv
// ----------------------------------------------------------------------------
// dcz_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dcz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/dcz_out.sv
// ----------------------------------------------------------------------------
// dcz_out
// output register for result items
// ----------------------------------------------------------------------------
module dcz_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dcz_pkg::t_result i_res,
    output logic             o_can_load,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [63:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tlast
);
    import dcz_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_res.out_from, r_res.out_weight, r_res.out_to, r_res.path_len};
    assign o_m_tuser  = r_res.status;
    assign o_m_tlast  = r_res.last;

    `include "assert_macros.svh"
    `DCZ_IMPLY(a_load_only_free, i_clk, i_rst_n, i_load, o_can_load)
    `DCZ_NEXT(a_load_shows, i_clk, i_rst_n, i_load, o_m_tvalid)
    `DCZ_ASSERT(a_no_reset_valid, i_clk, i_rst_n, !$past(!i_rst_n) || !o_m_tvalid)
endmodule

FILE: sim/dfs_cycle_through_vertex_zero_tb.sv
// ----------------------------------------------------------------------------
// dfs_cycle_through_vertex_zero_tb
// self-checking bench for the vertex-zero cycle search block
// ----------------------------------------------------------------------------
// Drives add, search, read and undefined request items over the input stream
// and keeps a behavioral copy of the adjacency lists and the depth-first walk.
// Each accepted add, search or read request predicts its result item, and
// every output item is checked field by field against the oldest prediction.
// A directed opening covers the special cases, then random graphs, mostly
// on vertices 0 to 15, are built, searched and read out. A last search and
// read-out closes the run. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module dfs_cycle_through_vertex_zero_tb;
    import dcz_pkg::*;

    // behavioral copy of the search block; predicts one result per defined request
    class cycle_predictor;
        bit [VERT_W-1:0] adj_to   [MAX_EDGES];
        bit [WGT_W-1:0]  adj_w    [MAX_EDGES];
        bit [LINK_W-1:0] adj_next [MAX_EDGES];
        bit [LINK_W-1:0] head     [MAX_VERTS];
        bit [LINK_W-1:0] tail     [MAX_VERTS];
        bit              seen     [MAX_VERTS];
        bit [VERT_W-1:0] pred     [MAX_VERTS];
        bit [WGT_W-1:0]  arr_w    [MAX_VERTS];
        bit [VERT_W-1:0] stk      [MAX_VERTS];
        int unsigned     n_edges;
        bit              found;
        int unsigned     clen;
        bit [VERT_W-1:0] rd_v;
        bit              rd_done;
        t_result         expected_results[$];
        int unsigned     n_drops, n_cycles, n_nocyc, n_reads, n_lasts;

        function new();
            foreach (head[i]) begin
                head[i] = NIL_LINK;
                tail[i] = NIL_LINK;
            end
            rd_done = 1'b1;
        endfunction

        function void walk_from_zero();
            int unsigned     top, n;
            bit [VERT_W-1:0] v, t, c;
            bit [LINK_W-1:0] cur;
            foreach (seen[i]) seen[i] = 1'b0;
            found = 1'b0;
            clen  = 0;
            top   = 0;
            stk[top++] = '0;
            while (top > 0 && !found) begin
                top--;
                v   = stk[top];
                cur = head[v];
                while (cur != NIL_LINK) begin
                    t = adj_to[cur];
                    // first edge back home closes the cycle
                    if (t == 0) begin
                        pred[0]  = v;
                        arr_w[0] = adj_w[cur];
                        found    = 1'b1;
                        break;
                    end
                    if (!seen[t]) begin
                        seen[t]  = 1'b1;
                        pred[t]  = v;
                        arr_w[t] = adj_w[cur];
                        if (top < MAX_VERTS) stk[top++] = t;
                    end
                    cur = adj_next[cur];
                end
            end
            if (found) begin
                c = pred[0];
                n = 1;
                while (c != 0 && n < MAX_VERTS) begin
                    n++;
                    c = pred[c];
                end
                clen    = n;
                rd_v    = '0;
                rd_done = 1'b0;
            end else begin
                rd_done = 1'b1;
            end
        endfunction

        // work out the result of one accepted request
        function void note_request(t_req req, bit [9:0] to, bit [31:0] w, bit [9:0] from);
            t_result r;
            bit [VERT_W-1:0] p;
            r = '0;
            r.status = ST_OK;
            case (req)
                REQ_ADD: begin
                    if (n_edges >= MAX_EDGES) begin
                        r.status = ST_FULL;
                        n_drops++;
                    end else begin
                        adj_to[n_edges]   = to;
                        adj_w[n_edges]    = w;
                        adj_next[n_edges] = NIL_LINK;
                        if (head[from] == NIL_LINK) head[from] = LINK_W'(n_edges);
                        else adj_next[tail[from]] = LINK_W'(n_edges);
                        tail[from] = LINK_W'(n_edges);
                        n_edges++;
                    end
                end
                REQ_SEARCH: begin
                    walk_from_zero();
                    if (found) begin
                        r.path_len = LEN_W'(clen);
                        n_cycles++;
                    end else begin
                        r.status = ST_NOCYC;
                        n_nocyc++;
                    end
                end
                REQ_READ: begin
                    n_reads++;
                    if (rd_done) begin
                        r.status = ST_EMPTY;
                    end else begin
                        p = pred[rd_v];
                        r.out_to     = rd_v;
                        r.out_weight = arr_w[rd_v];
                        r.out_from   = p;
                        if (p == 0) begin
                            rd_done = 1'b1;
                            r.last  = 1'b1;
                            n_lasts++;
                        end else begin
                            rd_v = p;
                        end
                    end
                end
                default: return;   // undefined code, nothing comes back
            endcase
            expected_results.insert(expected_results.size(), r);
        endfunction

        // compare one output item; empty string when it matches
        function string check_result(bit [63:0] data, bit [1:0] user, bit lst);
            t_result e;
            string   msg;
            if (expected_results.size() == 0)
                return $sformatf("unexpected result item data=%h status=%0d", data, user);
            e   = expected_results.pop_front();
            msg = "";
            if (user != e.status)
                msg = {msg, $sformatf(" status %0d/%0d", user, e.status)};
            if (data[10:0] != e.path_len)
                msg = {msg, $sformatf(" path_len %0d/%0d", data[10:0], e.path_len)};
            if (data[20:11] != e.out_to)
                msg = {msg, $sformatf(" out_to %0d/%0d", data[20:11], e.out_to)};
            if (data[52:21] != e.out_weight)
                msg = {msg, $sformatf(" out_weight %h/%h", data[52:21], e.out_weight)};
            if (data[62:53] != e.out_from)
                msg = {msg, $sformatf(" out_from %0d/%0d", data[62:53], e.out_from)};
            if (lst != e.last)
                msg = {msg, $sformatf(" last %0d/%0d", lst, e.last)};
            if (msg != "") msg = {"result mismatch (got/expected):", msg};
            return msg;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [55:0] i_s_tdata;   // edge_to, edge_weight, edge_from, zero pad
    logic [1:0]  i_s_tuser;   // req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;   // path_len, out_to, out_weight, out_from, zero pad
    logic [1:0]  o_m_tuser;   // status
    logic        o_m_tlast;   // last

    cycle_predictor cyc = new();
    int unsigned    n_errors  = 0;
    int unsigned    out_stall = 0;
    bit             sender_busy_idle = 1'b1;
    bit             sink_idle = 1'b1;

    dfs_cycle_through_vertex_zero i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop for a hung run
    initial begin
        #20000000;
        $display("dfs_cycle_through_vertex_zero test failed");
        $finish;
    end

    task automatic report(input string msg);
        n_errors++;
        $display("[%0t] %s", $realtime, msg);
    endtask

    // mostly short gaps, a few long ones
    function automatic int unsigned rand_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check on handshake, then pick next ready
    always @(posedge i_clk) begin
        string msg;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                msg = cyc.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
                if (msg != "") report(msg);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (sink_idle) out_stall = rand_gap();
            end
        end
    end

    // present one request item and hold it until taken
    task automatic send(input t_req req, input bit [9:0] to, input bit [31:0] w,
                        input bit [9:0] from);
        int unsigned gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {4'b0, from, w, to};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        cyc.note_request(req, to, w, from);
        gap = sender_busy_idle ? rand_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add(input bit [9:0] from, input bit [9:0] to, input bit [31:0] w);
        send(REQ_ADD, to, w, from);
    endtask

    task automatic drain(input int unsigned limit);
        int unsigned n;
        i_s_tvalid <= 1'b0;
        n = 0;
        while (cyc.expected_results.size() != 0 && n < limit) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // random item: small vertex set mostly, so cycles through zero show up
    task automatic random_item();
        int unsigned r;
        bit [9:0]    f, t;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
            f = 10'($urandom_range(0, 1023));
            t = 10'($urandom_range(0, 1023));
        end else begin
            f = 10'($urandom_range(0, 15));
            t = 10'($urandom_range(0, 15));
        end
        if (r < 55)      add(f, t, $urandom);
        else if (r < 65) send(REQ_SEARCH, 10'($urandom), $urandom, 10'($urandom));
        else if (r < 96) send(REQ_READ, 10'($urandom), $urandom, 10'($urandom));
        else             send(REQ_NONE, 10'($urandom), $urandom, 10'($urandom));
    endtask

    initial begin
        int unsigned n;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = REQ_ADD;
        i_m_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty graph: no cycle, nothing to read
        send(REQ_SEARCH, 0, 0, 0);
        send(REQ_READ, 0, 0, 0);
        // edge leaving zero but never returning
        add(0, 5, 32'h7fff_ffff);
        send(REQ_SEARCH, 0, 0, 0);
        send(REQ_READ, 10'h3ff, 32'hffff_ffff, 10'h3ff);
        // undefined request code gives no result
        send(REQ_NONE, 10'h3ff, 32'hffff_ffff, 10'h3ff);
        // cycle 0-5-1023-0 with extreme weights
        add(5, 1023, 32'h8000_0000);
        add(1023, 0, 32'hffff_ffff);
        add(1023, 1023, 32'h0);
        send(REQ_SEARCH, 0, 0, 0);
        // an edge added mid read-out leaves it alone
        send(REQ_READ, 0, 0, 0);
        add(0, 0, 32'h1234_5678);
        send(REQ_READ, 0, 0, 0);
        send(REQ_READ, 0, 0, 0);
        send(REQ_READ, 0, 0, 0);
        // self loop at zero is now the later edge; scanning zero's edges finds it before the longer cycle
        send(REQ_SEARCH, 0, 0, 0);
        repeat (4) send(REQ_READ, 0, 0, 0);

        // random part with an idle-sender pause partway through
        for (n = 0; n < 720; n++) begin
            if (n % 60 == 0) begin
                sender_busy_idle = ($urandom_range(0, 3) != 0);
                sink_idle        = ($urandom_range(0, 3) != 0);
            end
            if (n == 300) drain(200000);
            random_item();
        end

        // one more search over everything stored, then read it out
        sender_busy_idle = 1'b1;
        sink_idle        = 1'b1;
        send(REQ_SEARCH, 0, 0, 0);
        repeat (12) send(REQ_READ, 0, 0, 0);

        drain(500000);
        repeat (200) @(posedge i_clk);
        if (cyc.expected_results.size() != 0)
            report($sformatf("%0d result items never arrived",
                             cyc.expected_results.size()));

        $display("covered %0d searches with a cycle, %0d without, %0d reads (%0d last edges)",
                 cyc.n_cycles, cyc.n_nocyc, cyc.n_reads, cyc.n_lasts);
        $display("edges stored %0d, dropped on a full store %0d, mismatches %0d",
                 cyc.n_edges, cyc.n_drops, n_errors);
        if (n_errors == 0)
            $display("dfs_cycle_through_vertex_zero test passed");
        else
            $display("dfs_cycle_through_vertex_zero test failed");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/dcz_pkg.sv
rtl/dcz_ram.sv
rtl/dcz_out.sv
rtl/dfs_cycle_through_vertex_zero.sv
sim/dfs_cycle_through_vertex_zero_tb.sv
